// ===== design/hcb_pkg.sv =====
// ----------------------------------------------------------------------------
// hcb_pkg: shared types and constants of the Huffman code builder
// Item structs, sizing constants and the back end state encoding.
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int WEIGHT_W        = 28;
  localparam int FREQ_W          = 24;
  localparam int CODE_W          = 15;
  localparam int LEN_W           = 4;
  localparam int DEPTH_MAX       = 15;

  typedef struct packed {
    logic [7:0]        symbol;
    logic [FREQ_W-1:0] frequency;
    logic              last_symbol;
  } hcb_in_t;

  typedef struct packed {
    logic [7:0]        out_symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              last_code;
  } hcb_out_t;

  // Entry handed from the front end to the back end
  typedef struct packed {
    logic [7:0]        symbol;
    logic [FREQ_W-1:0] frequency;
    logic              store;
    logic              close;
  } hcb_cmd_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_MERGE,
    ST_ROOT,
    ST_POP,
    ST_EMIT
  } hcb_state_t;

endpackage

// ===== design/huffman_code_builder.sv =====
// A non-closing item passes the command queue and is stored in ST_LOAD; a
// closing item starts a build with one slot scan per merge, then a tree walk
// that emits one code per leaf. Pairs load one per cycle while the queue has
// room and the back end is in ST_LOAD; one set is built at a time.
// Reset: synchronous active low; clears the queue, set count and live slots.
// ----------------------------------------------------------------------------
// huffman_code_builder: top level
// Front classifier, command queue and build/walk back end.
// ----------------------------------------------------------------------------
module huffman_code_builder
  import hcb_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  hcb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output hcb_out_t out_data
);

  logic     cmd_valid, cmd_pop;
  hcb_cmd_t cmd_data;

  hcb_front #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .cmd_valid, .cmd_pop, .cmd_data
  );

  hcb_back #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_pop, .cmd_data,
    .out_valid, .out_stall, .out_data
  );

endmodule

// ===== design/hcb_front.sv =====
// ----------------------------------------------------------------------------
// hcb_front: input classifier
// Counts pairs of the open set, marks pairs over the bound as dropped and
// pushes commands into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module hcb_front
  import hcb_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  hcb_in_t  in_data,
  output logic     cmd_valid,
  input  logic     cmd_pop,
  output hcb_cmd_t cmd_data
);

  localparam int CW = $clog2(MAX_SYMBOLS + 1);

  logic [CW-1:0] count_r, count_nxt;
  hcb_cmd_t      q_r [2];
  logic          rd_r, wr_r;
  logic [1:0]    fill_r;
  logic          push;
  hcb_cmd_t      cmd_new;

  assign in_stall  = (fill_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd_data  = q_r[rd_r];

  // Classify: store while the set has room, close on last
  always_comb begin
    cmd_new.symbol    = in_data.symbol;
    cmd_new.frequency = in_data.frequency;
    cmd_new.store     = (count_r < CW'(MAX_SYMBOLS));
    cmd_new.close     = in_data.last_symbol;
    count_nxt         = count_r;
    if (push) begin
      if (in_data.last_symbol) begin
        count_nxt = '0;
      end else if (cmd_new.store) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rd_r    <= 1'b0;
      wr_r    <= 1'b0;
      fill_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_r <= ~wr_r;
      if (cmd_pop) rd_r <= ~rd_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= cmd_new;
  end

endmodule

// ===== design/hcb_back.sv =====
// ----------------------------------------------------------------------------
// hcb_back: tree build and code walk
// Stores pairs, merges the two lightest live slots one scan per merge, then
// walks the tree with an explicit stack and emits one code per leaf.
// ----------------------------------------------------------------------------
module hcb_back
  import hcb_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  output logic     cmd_pop,
  input  hcb_cmd_t cmd_data,
  output logic     out_valid,
  input  logic     out_stall,
  output hcb_out_t out_data
);

  localparam int NODES = 2 * MAX_SYMBOLS;
  localparam int NW    = $clog2(NODES);
  localparam int SW    = $clog2(MAX_SYMBOLS);
  localparam int CW    = $clog2(MAX_SYMBOLS + 1);
  localparam int PW    = $clog2(NODES + 1);

  hcb_state_t state_r, state_nxt;

  // Node tables
  logic [WEIGHT_W-1:0] weight_r [NODES];
  logic [NW-1:0]       left_r   [NODES];
  logic [NW-1:0]       right_r  [NODES];
  logic [7:0]          leafsym_r[MAX_SYMBOLS];
  logic [NW-1:0]       slot_r   [MAX_SYMBOLS];
  logic [MAX_SYMBOLS-1:0] live_r;

  // Walk stack
  logic [NW-1:0]       stk_node_r [NODES];
  logic [CODE_W-1:0]   stk_code_r [NODES];
  logic [LEN_W-1:0]    stk_len_r  [NODES];
  logic [PW-1:0]       sp_r;

  logic [CW-1:0]       n_r, live_cnt_r;
  logic [NW-1:0]       next_r;
  logic [CW-1:0]       scan_r;
  logic                a_ok_r, b_ok_r;
  logic [SW-1:0]       a_r, b_r;
  logic [WEIGHT_W-1:0] wa_r, wb_r;
  logic [NW-1:0]       cur_node_r;
  logic [CODE_W-1:0]   cur_code_r;
  logic [LEN_W-1:0]    cur_len_r;
  hcb_out_t            obuf_r;
  logic                ovalid_r;

  logic [WEIGHT_W-1:0] w_scan;
  logic                out_free;

  assign out_free  = !ovalid_r || !out_stall;
  assign out_valid = ovalid_r;
  assign out_data  = obuf_r;
  assign w_scan    = weight_r[slot_r[scan_r[SW-1:0]]];
  assign cmd_pop   = (state_r == ST_LOAD) && cmd_valid;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:  if (cmd_valid && cmd_data.close) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (live_cnt_r < 2) state_nxt = ST_ROOT;
        else if (scan_r == n_r) state_nxt = ST_MERGE;
      end
      ST_MERGE: state_nxt = ST_SCAN;
      ST_ROOT: begin
        if (scan_r == n_r) state_nxt = ST_LOAD;
        else if (live_r[scan_r[SW-1:0]]) state_nxt = ST_POP;
      end
      ST_POP:   if (sp_r == '0) state_nxt = ST_LOAD;
                else state_nxt = ST_EMIT;
      ST_EMIT:  if (cur_node_r >= NW'(n_r) || out_free) state_nxt = ST_POP;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      live_r   <= '0;
      n_r      <= '0;
      ovalid_r <= 1'b0;
      sp_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      case (state_r)
        ST_LOAD: begin
          if (cmd_valid) begin
            if (cmd_data.store) begin
              live_r[n_r[SW-1:0]] <= 1'b1;
              n_r <= n_r + 1'b1;
            end
          end
        end
        ST_ROOT: begin
          if (scan_r != n_r && live_r[scan_r[SW-1:0]]) sp_r <= PW'(1);
        end
        ST_POP: begin
          if (sp_r == '0) begin
            live_r <= '0;
            n_r    <= '0;
          end else begin
            sp_r <= sp_r - 1'b1;
          end
        end
        ST_MERGE: live_r[b_r] <= 1'b0;
        ST_EMIT: begin
          if (cur_node_r < NW'(n_r)) begin
            if (out_free) begin
              ovalid_r <= 1'b1;
            end
          end else if (PW'(sp_r) + PW'(2) <= PW'(NODES)) begin
            sp_r <= sp_r + PW'(2);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        scan_r     <= '0;
        a_ok_r     <= 1'b0;
        b_ok_r     <= 1'b0;
        live_cnt_r <= n_r + CW'(cmd_data.store);
        next_r     <= NW'(n_r) + NW'(cmd_data.store);
        if (cmd_valid && cmd_data.store) begin
          weight_r[NW'(n_r)]      <= WEIGHT_W'(cmd_data.frequency);
          slot_r[n_r[SW-1:0]]     <= NW'(n_r);
          leafsym_r[n_r[SW-1:0]]  <= cmd_data.symbol;
        end
      end
      ST_SCAN: begin
        if (live_cnt_r < 2) begin
          scan_r <= '0;
        end else if (scan_r != n_r) begin
          scan_r <= scan_r + 1'b1;
          if (live_r[scan_r[SW-1:0]]) begin
            if (!a_ok_r || w_scan < wa_r) begin
              b_r <= a_r; wb_r <= wa_r; b_ok_r <= a_ok_r;
              a_r <= scan_r[SW-1:0]; wa_r <= w_scan; a_ok_r <= 1'b1;
            end else if (!b_ok_r || w_scan < wb_r) begin
              b_r <= scan_r[SW-1:0]; wb_r <= w_scan; b_ok_r <= 1'b1;
            end
          end
        end
      end
      ST_MERGE: begin
        weight_r[next_r] <= wa_r + wb_r;
        left_r[next_r]   <= slot_r[a_r];
        right_r[next_r]  <= slot_r[b_r];
        slot_r[a_r]      <= next_r;
        next_r           <= next_r + 1'b1;
        live_cnt_r       <= live_cnt_r - 1'b1;
        scan_r           <= '0;
        a_ok_r           <= 1'b0;
        b_ok_r           <= 1'b0;
      end
      ST_ROOT: begin
        if (scan_r != n_r) begin
          if (live_r[scan_r[SW-1:0]]) begin
            stk_node_r[0] <= slot_r[scan_r[SW-1:0]];
            stk_code_r[0] <= '0;
            stk_len_r[0]  <= '0;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
      end
      ST_POP: begin
        if (sp_r != '0) begin
          cur_node_r <= stk_node_r[sp_r[NW-1:0] - 1'b1];
          cur_code_r <= stk_code_r[sp_r[NW-1:0] - 1'b1];
          cur_len_r  <= stk_len_r[sp_r[NW-1:0] - 1'b1];
        end
      end
      ST_EMIT: begin
        if (cur_node_r < NW'(n_r)) begin
          if (out_free) begin
            obuf_r.out_symbol  <= leafsym_r[cur_node_r[SW-1:0]];
            obuf_r.code_bits   <= cur_code_r;
            obuf_r.code_length <= cur_len_r;
            obuf_r.last_code   <= (sp_r == '0);
          end
        end else if (PW'(sp_r) + PW'(2) <= PW'(NODES)) begin
          stk_node_r[sp_r[NW-1:0]]        <= right_r[cur_node_r];
          stk_code_r[sp_r[NW-1:0]]        <= {cur_code_r[CODE_W-2:0], 1'b1};
          stk_len_r[sp_r[NW-1:0]]         <= (cur_len_r == LEN_W'(DEPTH_MAX)) ?
                                             cur_len_r : cur_len_r + 1'b1;
          stk_node_r[sp_r[NW-1:0] + 1'b1] <= left_r[cur_node_r];
          stk_code_r[sp_r[NW-1:0] + 1'b1] <= {cur_code_r[CODE_W-2:0], 1'b0};
          stk_len_r[sp_r[NW-1:0] + 1'b1]  <= (cur_len_r == LEN_W'(DEPTH_MAX)) ?
                                             cur_len_r : cur_len_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/hcb_checker.sv =====
// ----------------------------------------------------------------------------
// hcb_checker: port level checks
// Handshake and output sanity seen from the top level ports.
// ----------------------------------------------------------------------------
module hcb_checker
  import hcb_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input hcb_out_t out_data
);

  // Stalled input item stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("stalled input item withdrawn");

  // Held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Zero length code carries no bits
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.code_length == '0 |-> out_data.code_bits == '0)
    else $error("bits set on empty code");

  // Code fits its length when shorter than DEPTH_MAX
  a_fit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.code_length < LEN_W'(DEPTH_MAX) |->
      (out_data.code_bits >> out_data.code_length) == '0)
    else $error("code wider than length");

  // No result during reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind huffman_code_builder hcb_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
